### sv/line_segment_clipper_assert.svh
// Assertion macros shared by the line segment clipper modules.
// Expects signals named clk and rst_n in the scope of use.
`ifndef LINE_SEGMENT_CLIPPER_ASSERT_SVH
`define LINE_SEGMENT_CLIPPER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lsc_pkg.sv
// Shared constants and types for the line segment clipper.
// No dependencies.
package lsc_pkg;

    localparam int LSC_COORD_BITS    = 16;
    localparam int LSC_MAX_CLIPS     = 4;
    localparam int LSC_STEP_BITS     = $clog2(LSC_MAX_CLIPS + 1);
    localparam int LSC_WIN_RESET     = 150;
    localparam int LSC_ADDR_BITS     = 4;
    localparam int LSC_APB_DATA_BITS = 32;

    // register map, word index
    typedef enum logic [1:0] {
        REG_XMIN,
        REG_XMAX,
        REG_YMIN,
        REG_YMAX
    } lsc_reg_t;

    // outcode bit positions
    localparam int OC_LEFT   = 0;
    localparam int OC_RIGHT  = 1;
    localparam int OC_BOTTOM = 2;
    localparam int OC_TOP    = 3;

    typedef logic [3:0] lsc_outcode_t;

    // status of the shared multiply/divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } lsc_md_stat_t;

endpackage

### sv/line_segment_clipper.sv
// Cohen-Sutherland line segment clipper, top level.
// Depends on lsc_pkg, lsc_cfg and lsc_muldiv.
//
// Usage:
//   s_* channel takes one segment per transfer; s_tdata = {by, bx, ay, ax},
//   ax in the low COORD_BITS. m_* channel returns one result per segment:
//   m_tuser[0] = accepted, m_tdata = {clip_by, clip_bx, clip_ay, clip_ax}
//   (all zero when the segment is rejected).
//   The APB port holds the window: xmin, xmax, ymin, ymax at byte 0/4/8/12.
//   Write it only while no segment is in flight.
// Timing: s_tready is high only while the sequencer is idle. A segment makes
//   0..4 edge crossings between its transfer and the result. The next
//   transfer can follow in the cycle after the result is loaded. Each crossing
//   runs once through the single shared multiply/divide unit, one quotient bit
//   a cycle; a crossing far off the coordinate range clamps early and is shorter.
// The result sits in an output register; while the receiver stalls the next
//   segment is taken and computed, and the sequencer waits only when a second
//   result is ready before the first left.
// Reset: asynchronous, active low; window returns to +-150, both channels empty.
`include "line_segment_clipper_assert.svh"
module line_segment_clipper #(
    parameter  int COORD_BITS = lsc_pkg::LSC_COORD_BITS,
    localparam int TDATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // APB configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lsc_pkg::LSC_ADDR_BITS-1:0]      paddr,
    input  logic [lsc_pkg::LSC_APB_DATA_BITS-1:0]  pwdata,
    output logic [lsc_pkg::LSC_APB_DATA_BITS-1:0]  prdata,
    output logic                                   pready,
    // segment in
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [TDATA_BITS-1:0]                  s_tdata,  // ax, ay, bx, by
    // result out
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [TDATA_BITS-1:0]                  m_tdata,  // clip_ax, clip_ay, clip_bx, clip_by
    output logic [0:0]                             m_tuser   // accepted
);
    import lsc_pkg::*;

    localparam int DW = COORD_BITS + 1;   // coordinate differences
    localparam int QW = COORD_BITS + 3;   // clamped quotient and sum

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]         diff_t;
    typedef logic signed [QW-1:0]         wide_t;

    localparam coord_t C_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t C_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_CALC,
        S_FIN,
        S_DONE
    } state_t;

    // window
    coord_t win_xmin;
    coord_t win_xmax;
    coord_t win_ymin;
    coord_t win_ymax;

    // sequencer and working registers
    state_t                   state_reg;
    coord_t                   x0_reg;
    coord_t                   y0_reg;
    coord_t                   x1_reg;
    coord_t                   y1_reg;
    logic [LSC_STEP_BITS-1:0] steps_reg;
    logic                     acc_reg;
    coord_t                   p0_reg;
    coord_t                   edge_reg;
    diff_t                    dp_reg;
    diff_t                    de_reg;
    diff_t                    dq_reg;
    logic                     horiz_reg;   // crossing a vertical edge: x fixed
    logic                     sel1_reg;    // moving endpoint b
    logic                     start_reg;
    logic                     m_tvalid_reg;
    logic [TDATA_BITS-1:0]    m_tdata_reg;
    logic [0:0]               m_tuser_reg;

    // combinational
    lsc_outcode_t c0;
    lsc_outcode_t c1;
    lsc_outcode_t csel;
    logic         horiz;
    coord_t       edge_sel;
    coord_t       p0;
    coord_t       p1;
    coord_t       q0;
    coord_t       q1;
    wide_t        md_q;
    lsc_md_stat_t md_stat;
    wide_t        cross_sum;
    coord_t       cross_val;
    coord_t       nx;
    coord_t       ny;
    logic         out_load;

    function automatic lsc_outcode_t outcode(input coord_t x, input coord_t y,
                                             input coord_t xmin, input coord_t xmax,
                                             input coord_t ymin, input coord_t ymax);
        lsc_outcode_t c;
        c = '0;
        if (y > ymax)
            c[OC_TOP] = 1'b1;
        else if (y < ymin)
            c[OC_BOTTOM] = 1'b1;
        if (x > xmax)
            c[OC_RIGHT] = 1'b1;
        else if (x < xmin)
            c[OC_LEFT] = 1'b1;
        return c;
    endfunction

    function automatic coord_t csat(input wide_t v);
        if (v > QW'(C_HI))
            return C_HI;
        else if (v < QW'(C_LO))
            return C_LO;
        else
            return v[COORD_BITS-1:0];
    endfunction

    lsc_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .win_xmin (win_xmin),
        .win_xmax (win_xmax),
        .win_ymin (win_ymin),
        .win_ymax (win_ymax)
    );

    lsc_muldiv #(
        .COORD_BITS (COORD_BITS)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .dp    (dp_reg),
        .de    (de_reg),
        .dq    (dq_reg),
        .q     (md_q),
        .stat  (md_stat)
    );

    assign c0   = outcode(x0_reg, y0_reg, win_xmin, win_xmax, win_ymin, win_ymax);
    assign c1   = outcode(x1_reg, y1_reg, win_xmin, win_xmax, win_ymin, win_ymax);
    assign csel = (c0 != '0) ? c0 : c1;

    // edge priority: top, bottom, right, left
    always_comb
    begin
        priority if (csel[OC_TOP])
        begin
            horiz    = 1'b0;
            edge_sel = win_ymax;
        end
        else if (csel[OC_BOTTOM])
        begin
            horiz    = 1'b0;
            edge_sel = win_ymin;
        end
        else if (csel[OC_RIGHT])
        begin
            horiz    = 1'b1;
            edge_sel = win_xmax;
        end
        else
        begin
            horiz    = 1'b1;
            edge_sel = win_xmin;
        end
    end

    // p runs along the edge, q across it
    assign p0 = horiz ? y0_reg : x0_reg;
    assign p1 = horiz ? y1_reg : x1_reg;
    assign q0 = horiz ? x0_reg : y0_reg;
    assign q1 = horiz ? x1_reg : y1_reg;

    assign cross_sum = QW'(p0_reg) + md_q;
    assign cross_val = (dq_reg == '0) ? p0_reg : csat(cross_sum);
    assign nx        = horiz_reg ? edge_reg : cross_val;
    assign ny        = horiz_reg ? cross_val : edge_reg;

    // output register takes a new result when empty or emptying this cycle
    assign out_load  = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            x0_reg       <= '0;
            y0_reg       <= '0;
            x1_reg       <= '0;
            y1_reg       <= '0;
            steps_reg    <= '0;
            acc_reg      <= 1'b0;
            p0_reg       <= '0;
            edge_reg     <= '0;
            dp_reg       <= '0;
            de_reg       <= '0;
            dq_reg       <= '0;
            horiz_reg    <= 1'b0;
            sel1_reg     <= 1'b0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready && !out_load)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        x0_reg    <= s_tdata[COORD_BITS-1:0];
                        y0_reg    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
                        x1_reg    <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
                        y1_reg    <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
                        steps_reg <= '0;
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    priority if ((c0 | c1) == '0)
                    begin
                        acc_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (((c0 & c1) != '0) ||
                             (steps_reg == LSC_STEP_BITS'(LSC_MAX_CLIPS)))
                    begin
                        // trivially outside, or still open after the last crossing
                        acc_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        p0_reg    <= p0;
                        edge_reg  <= edge_sel;
                        dp_reg    <= DW'(p1) - DW'(p0);
                        de_reg    <= DW'(edge_sel) - DW'(q0);
                        dq_reg    <= DW'(q1) - DW'(q0);
                        horiz_reg <= horiz;
                        sel1_reg  <= (c0 == '0);
                        steps_reg <= steps_reg + 1'b1;
                        start_reg <= 1'b1;
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    if (md_stat.done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (sel1_reg)
                    begin
                        x1_reg <= nx;
                        y1_reg <= ny;
                    end
                    else
                    begin
                        x0_reg <= nx;
                        y0_reg <= ny;
                    end
                    state_reg <= S_TEST;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        m_tuser_reg[0] <= acc_reg;
                        m_tdata_reg    <= acc_reg ?
                            TDATA_BITS'({y1_reg, x1_reg, y0_reg, x0_reg}) : '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `LSC_ASSERT_IMP(a_rejected_zero, m_tvalid_reg && !m_tuser_reg[0], m_tdata_reg == '0, "rejected result carries coordinates")
    `LSC_ASSERT_IMP(a_done_in_calc, md_stat.done, state_reg == S_CALC, "divider result outside calc state")
    `LSC_ASSERT_IMP(a_start_idle_unit, start_reg, !md_stat.busy && (steps_reg <= LSC_STEP_BITS'(LSC_MAX_CLIPS)), "crossing started while unit busy or over limit")

endmodule

### sv/lsc_cfg.sv
// APB register file holding the clip window.
// Depends on lsc_pkg.
module lsc_cfg #(
    parameter int COORD_BITS = lsc_pkg::LSC_COORD_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lsc_pkg::LSC_ADDR_BITS-1:0]      paddr,
    input  logic [lsc_pkg::LSC_APB_DATA_BITS-1:0]  pwdata,
    output logic [lsc_pkg::LSC_APB_DATA_BITS-1:0]  prdata,
    output logic                                   pready,
    output logic signed [COORD_BITS-1:0]           win_xmin,
    output logic signed [COORD_BITS-1:0]           win_xmax,
    output logic signed [COORD_BITS-1:0]           win_ymin,
    output logic signed [COORD_BITS-1:0]           win_ymax
);
    import lsc_pkg::*;

    localparam logic signed [COORD_BITS-1:0] WIN_POS = COORD_BITS'(LSC_WIN_RESET);
    localparam logic signed [COORD_BITS-1:0] WIN_NEG = -WIN_POS;

    logic signed [COORD_BITS-1:0] win_xmin_reg;
    logic signed [COORD_BITS-1:0] win_xmax_reg;
    logic signed [COORD_BITS-1:0] win_ymin_reg;
    logic signed [COORD_BITS-1:0] win_ymax_reg;
    lsc_reg_t                     reg_idx;
    logic                         wr_en;
    logic signed [COORD_BITS-1:0] wr_val;

    assign pready  = 1'b1;
    assign reg_idx = lsc_reg_t'(paddr[LSC_ADDR_BITS-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign wr_val  = pwdata[COORD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_xmin_reg <= WIN_NEG;
            win_xmax_reg <= WIN_POS;
            win_ymin_reg <= WIN_NEG;
            win_ymax_reg <= WIN_POS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_XMIN: win_xmin_reg <= wr_val;
                REG_XMAX: win_xmax_reg <= wr_val;
                REG_YMIN: win_ymin_reg <= wr_val;
                REG_YMAX: win_ymax_reg <= wr_val;
            endcase
        end
    end

    // reads return the sign-extended value
    always_comb
    begin
        unique case (reg_idx)
            REG_XMIN: prdata = LSC_APB_DATA_BITS'(win_xmin_reg);
            REG_XMAX: prdata = LSC_APB_DATA_BITS'(win_xmax_reg);
            REG_YMIN: prdata = LSC_APB_DATA_BITS'(win_ymin_reg);
            REG_YMAX: prdata = LSC_APB_DATA_BITS'(win_ymax_reg);
        endcase
    end

    assign win_xmin = win_xmin_reg;
    assign win_xmax = win_xmax_reg;
    assign win_ymin = win_ymin_reg;
    assign win_ymax = win_ymax_reg;

endmodule

### sv/lsc_muldiv.sv
// Shared multiply/divide unit: trunc(dp * de / dq), magnitude clamped at 2^(N+1).
// Multiply, range check, then one quotient bit per cycle and the sign. Depends on lsc_pkg.
`include "line_segment_clipper_assert.svh"
module lsc_muldiv #(
    parameter int COORD_BITS = lsc_pkg::LSC_COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_BITS:0]    dp,
    input  logic signed [COORD_BITS:0]    de,
    input  logic signed [COORD_BITS:0]    dq,
    output logic signed [COORD_BITS+2:0]  q,
    output lsc_pkg::lsc_md_stat_t         stat
);
    import lsc_pkg::*;

    localparam int MW = COORD_BITS + 1;     // operand magnitude
    localparam int PW = 2 * MW;             // product
    localparam int QW = MW + 2;             // signed quotient
    localparam int CW = $clog2(MW + 1);
    localparam logic [MW:0]          QSAT   = {1'b1, {MW{1'b0}}};
    localparam logic signed [QW-1:0] QSAT_S = QW'(QSAT);

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_CHK,
        M_DIV,
        M_SIGN
    } md_state_t;

    md_state_t              state_reg;
    logic [MW-1:0]          a_reg;
    logic [MW-1:0]          b_reg;
    logic [MW-1:0]          d_reg;
    logic                   neg_reg;
    logic [PW-1:0]          prod_reg;
    logic [MW-1:0]          rem_reg;
    logic [MW-1:0]          sh_reg;
    logic [CW-1:0]          cnt_reg;
    logic signed [QW-1:0]   q_reg;
    logic                   done_reg;

    logic [MW:0]            trial;
    logic [MW:0]            trial_sub;
    logic                   trial_ge;
    logic                   ovf;

    function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
        return v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    function automatic logic signed [QW-1:0] apply_sign(input logic [MW:0] m, input logic n);
        logic signed [QW-1:0] sm;
        sm = $signed({1'b0, m});
        return n ? -sm : sm;
    endfunction

    assign trial     = {rem_reg, sh_reg[MW-1]};
    assign trial_sub = trial - {1'b0, d_reg};
    assign trial_ge  = trial >= {1'b0, d_reg};
    // quotient would reach 2^(N+1): clamp (also catches a zero divisor)
    assign ovf       = prod_reg >= {d_reg, {MW{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            d_reg     <= '0;
            neg_reg   <= 1'b0;
            prod_reg  <= '0;
            rem_reg   <= '0;
            sh_reg    <= '0;
            cnt_reg   <= '0;
            q_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= mag(dp);
                        b_reg     <= mag(de);
                        d_reg     <= mag(dq);
                        neg_reg   <= dp[MW-1] ^ de[MW-1] ^ dq[MW-1];
                        state_reg <= M_MUL;
                    end
                end
                M_MUL:
                begin
                    prod_reg  <= PW'(a_reg) * PW'(b_reg);
                    state_reg <= M_CHK;
                end
                M_CHK:
                begin
                    if (ovf)
                    begin
                        q_reg     <= apply_sign(QSAT, neg_reg);
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                    else
                    begin
                        rem_reg   <= prod_reg[PW-1:MW];
                        sh_reg    <= prod_reg[MW-1:0];
                        cnt_reg   <= CW'(MW);
                        state_reg <= M_DIV;
                    end
                end
                M_DIV:
                begin
                    rem_reg <= trial_ge ? trial_sub[MW-1:0] : trial[MW-1:0];
                    sh_reg  <= {sh_reg[MW-2:0], trial_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= M_SIGN;
                    end
                end
                M_SIGN:
                begin
                    q_reg     <= apply_sign({1'b0, sh_reg}, neg_reg);
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign q         = q_reg;
    assign stat.busy = (state_reg != M_IDLE);
    assign stat.done = done_reg;

    `LSC_ASSERT_IMP(a_md_rem_lt_div, state_reg == M_DIV, rem_reg < d_reg, "remainder not below divisor")
    `LSC_ASSERT_IMP(a_md_q_range, done_reg, (q_reg <= QSAT_S) && (q_reg >= -QSAT_S), "quotient beyond clamp")
    `LSC_ASSERT_IMP(a_md_cnt_range, state_reg == M_DIV, (cnt_reg != '0) && (cnt_reg <= CW'(MW)), "bit counter out of range")

endmodule

### tb/line_segment_clipper_check.sv
// Scoreboard for the line segment clipper: follows window writes on the APB port,
// predicts one clip result per segment transfer and compares it with the result channel.
// Depends on lsc_pkg.
module line_segment_clipper_check (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                psel,
    input  logic                                                penable,
    input  logic                                                pwrite,
    input  logic                                                pready,
    input  logic [lsc_pkg::LSC_ADDR_BITS-1:0]                   paddr,
    input  logic [lsc_pkg::LSC_APB_DATA_BITS-1:0]               pwdata,
    input  logic                                                s_tvalid,
    input  logic                                                s_tready,
    input  logic [((4*lsc_pkg::LSC_COORD_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                                m_tvalid,
    input  logic                                                m_tready,
    input  logic [((4*lsc_pkg::LSC_COORD_BITS+7)/8)*8-1:0]      m_tdata,
    input  logic [0:0]                                          m_tuser,
    output int                                                  fail_count,
    output int                                                  results_pending
);
    import lsc_pkg::*;

    localparam int CW = LSC_COORD_BITS;
    localparam longint COORD_HI = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam longint unsigned QUOT_SAT = 64'd1 << 62;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic   accepted;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } clip_result_t;

    coord_t       win_xmin;
    coord_t       win_xmax;
    coord_t       win_ymin;
    coord_t       win_ymax;
    clip_result_t clip_q[$];
    clip_result_t want;
    clip_result_t got;
    int           mismatches;
    int           result_index;

    function automatic lsc_outcode_t region_code(longint x, longint y);
        lsc_outcode_t c;
        c = '0;
        if (y > win_ymax)
            c[OC_TOP] = 1'b1;
        else if (y < win_ymin)
            c[OC_BOTTOM] = 1'b1;
        if (x > win_xmax)
            c[OC_RIGHT] = 1'b1;
        else if (x < win_xmin)
            c[OC_LEFT] = 1'b1;
        return c;
    endfunction

    // p0 + (p1 - p0) * (bound - q0) / (q1 - q0), quotient truncated toward zero,
    // result clamped to the coordinate range
    function automatic longint edge_crossing(longint p0, longint p1, longint q0, longint q1,
                                             longint bound);
        longint          dp;
        longint          dn;
        longint          dd;
        longint          moved;
        longint unsigned mag_p;
        longint unsigned mag_n;
        longint unsigned mag_d;
        longint unsigned quo;
        if (q1 == q0)
            return p0;
        dp = p1 - p0;
        dn = bound - q0;
        dd = q1 - q0;
        mag_p = (dp < 0) ? -dp : dp;
        mag_n = (dn < 0) ? -dn : dn;
        mag_d = (dd < 0) ? -dd : dd;
        quo = (mag_p * mag_n) / mag_d;
        if (quo > QUOT_SAT)
            quo = QUOT_SAT;
        moved = (((dp < 0) != (dn < 0)) != (dd < 0)) ? -$signed(quo) : $signed(quo);
        moved = p0 + moved;
        if (moved > COORD_HI)
            moved = COORD_HI;
        else if (moved < COORD_LO)
            moved = COORD_LO;
        return moved;
    endfunction

    function automatic clip_result_t clip_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        longint       x0;
        longint       y0;
        longint       x1;
        longint       y1;
        longint       nx;
        longint       ny;
        lsc_outcode_t c0;
        lsc_outcode_t c1;
        lsc_outcode_t c;
        int           crossings;
        logic         settled;
        clip_result_t res;
        x0 = ax;
        y0 = ay;
        x1 = bx;
        y1 = by;
        c0 = region_code(x0, y0);
        c1 = region_code(x1, y1);
        crossings = 0;
        settled = 1'b0;
        res = '0;
        while (!settled)
        begin
            if ((c0 | c1) == '0)
            begin
                res.accepted = 1'b1;
                res.ax = x0[CW-1:0];
                res.ay = y0[CW-1:0];
                res.bx = x1[CW-1:0];
                res.by = y1[CW-1:0];
                settled = 1'b1;
            end
            else if ((c0 & c1) != '0 || crossings == LSC_MAX_CLIPS)
            begin
                // rejected; running out of crossings only happens with an inverted window
                settled = 1'b1;
            end
            else
            begin
                crossings++;
                c = (c0 != '0) ? c0 : c1;
                if (c[OC_TOP])
                begin
                    nx = edge_crossing(x0, x1, y0, y1, win_ymax);
                    ny = win_ymax;
                end
                else if (c[OC_BOTTOM])
                begin
                    nx = edge_crossing(x0, x1, y0, y1, win_ymin);
                    ny = win_ymin;
                end
                else if (c[OC_RIGHT])
                begin
                    ny = edge_crossing(y0, y1, x0, x1, win_xmax);
                    nx = win_xmax;
                end
                else
                begin
                    ny = edge_crossing(y0, y1, x0, x1, win_xmin);
                    nx = win_xmin;
                end
                if (c0 != '0)
                begin
                    x0 = nx;
                    y0 = ny;
                    c0 = region_code(x0, y0);
                end
                else
                begin
                    x1 = nx;
                    y1 = ny;
                    c1 = region_code(x1, y1);
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_xmin = coord_t'(-LSC_WIN_RESET);
            win_xmax = coord_t'(LSC_WIN_RESET);
            win_ymin = coord_t'(-LSC_WIN_RESET);
            win_ymax = coord_t'(LSC_WIN_RESET);
            clip_q.delete();
            mismatches = 0;
            result_index = 0;
            fail_count <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (lsc_reg_t'(paddr[3:2]))
                    REG_XMIN: win_xmin = pwdata[CW-1:0];
                    REG_XMAX: win_xmax = pwdata[CW-1:0];
                    REG_YMIN: win_ymin = pwdata[CW-1:0];
                    REG_YMAX: win_ymax = pwdata[CW-1:0];
                endcase
            end
            if (s_tvalid && s_tready)
                clip_q.push_back(clip_segment(s_tdata[CW-1:0], s_tdata[2*CW-1:CW],
                                              s_tdata[3*CW-1:2*CW], s_tdata[4*CW-1:3*CW]));
            if (m_tvalid && m_tready)
            begin
                got.accepted = m_tuser[0];
                got.ax = m_tdata[CW-1:0];
                got.ay = m_tdata[2*CW-1:CW];
                got.bx = m_tdata[3*CW-1:2*CW];
                got.by = m_tdata[4*CW-1:3*CW];
                if (clip_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("result %0d arrived with no segment outstanding", result_index);
                    mismatches++;
                end
                else
                begin
                    want = clip_q.pop_front();
                    if (got.accepted !== want.accepted || got.ax !== want.ax ||
                        got.ay !== want.ay || got.bx !== want.bx || got.by !== want.by)
                    begin
                        if (mismatches < 10)
                            $display({"result %0d mismatch: expected acc=%0b (%0d,%0d)-(%0d,%0d)",
                                      ", got acc=%0b (%0d,%0d)-(%0d,%0d)"},
                                     result_index, want.accepted, want.ax, want.ay,
                                     want.bx, want.by, got.accepted, got.ax, got.ay,
                                     got.bx, got.by);
                        mismatches++;
                    end
                end
                result_index++;
            end
            fail_count <= mismatches;
            results_pending <= clip_q.size();
        end
    end

endmodule

### tb/line_segment_clipper_test.sv
// Top of the line segment clipper testbench: clock, reset, APB window writes,
// segment stimulus and result back-pressure; checking lives in line_segment_clipper_check.
// Depends on lsc_pkg, line_segment_clipper and line_segment_clipper_check.
module line_segment_clipper_test;
    import lsc_pkg::*;

    localparam int CW          = LSC_COORD_BITS;
    localparam int TDATA_BITS  = ((4 * CW + 7) / 8) * 8;
    localparam int CLK_PERIOD  = 12;
    localparam int BATCHES     = 8;
    localparam int BATCH_ITEMS = 97;
    // drain wait at the end, longer than the worst case segment takes
    localparam int DRAIN_CYCLES = 100;
    // long receiver hold-off so the block backs up and stalls s_tready
    localparam int RX_HOLD_CYCLES = 400;
    // ~800 segments plus gaps, stalls and holds stay far below this
    localparam int CYCLE_LIMIT = 400000;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [LSC_ADDR_BITS-1:0]           paddr = '0;
    logic [LSC_APB_DATA_BITS-1:0]       pwdata = '0;
    logic [LSC_APB_DATA_BITS-1:0]       prdata;
    logic                               pready;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [TDATA_BITS-1:0]              s_tdata = '0;   // ax, ay, bx, by (low bits first)
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [TDATA_BITS-1:0]              m_tdata;        // clip_ax, clip_ay, clip_bx, clip_by
    logic [0:0]                         m_tuser;        // accepted

    int fail_count;
    int results_pending;
    int cycle_count = 0;

    // idle rates in percent; the sender's is read only by the stimulus process
    int send_idle_pct = 18;
    int recv_idle_pct = 75;

    // receiver hold-off: stimulus bumps the request, the receiver process counts it out
    int rx_hold_req = 0;
    int rx_hold_ack = 0;
    int rx_hold_left = 0;

    // current window as seen by the stimulus, sorted so low <= high on each axis
    int wx_lo = -LSC_WIN_RESET;
    int wx_hi = LSC_WIN_RESET;
    int wy_lo = -LSC_WIN_RESET;
    int wy_hi = LSC_WIN_RESET;

    line_segment_clipper dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    line_segment_clipper_check checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result-side back-pressure: random stalls, or a counted hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            m_tready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_hold_req != rx_hold_ack)
        begin
            rx_hold_ack <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // one coordinate: mostly around the window, sometimes on or next to an edge,
    // sometimes anywhere in the 16-bit range or at its extremes
    function automatic int pick_coord(int lo, int hi);
        int span;
        int v;
        span = hi - lo + 1;
        case ($urandom_range(7))
            0: v = rand_in(-32768, 32767);
            1:
            begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            2:
            begin
                case ($urandom_range(3))
                    0: v = lo - 1;
                    1: v = lo;
                    2: v = hi;
                    default: v = hi + 1;
                endcase
            end
            default: v = lo - span / 2 + int'($urandom_range(2 * span));
        endcase
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // Every task starts and ends just after a rising edge, so each drives its
    // signals with one nonblocking update per edge.

    // APB write: setup cycle, access cycle, register written at the access edge
    task automatic write_window_reg(lsc_reg_t idx, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // stop offering segments and wait for every outstanding result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // window registers are written only with the block idle
    task automatic set_window(int xmin, int xmax, int ymin, int ymax);
        wait_drained();
        write_window_reg(REG_XMIN, xmin);
        write_window_reg(REG_XMAX, xmax);
        write_window_reg(REG_YMIN, ymin);
        write_window_reg(REG_YMAX, ymax);
        wx_lo = (xmin < xmax) ? xmin : xmax;
        wx_hi = (xmin < xmax) ? xmax : xmin;
        wy_lo = (ymin < ymax) ? ymin : ymax;
        wy_hi = (ymin < ymax) ? ymax : ymin;
    endtask

    // one segment transfer; valid stays high into the next call unless a gap is taken
    task automatic send_segment(int ax, int ay, int bx, int by);
        if (int'($urandom_range(99)) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(4) == 0) ? 40 : 3))
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {by[CW-1:0], bx[CW-1:0], ay[CW-1:0], ax[CW-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial
    begin
        int batch;
        int n;
        int xa;
        int xb;
        int ya;
        int yb;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed segments against the reset window of +-150.
        send_segment(0, 0, 10, -10);                      // fully inside
        send_segment(-32768, -32768, 32767, 32767);       // extreme diagonal through
        send_segment(32767, -32768, -32768, 32767);       // other diagonal
        send_segment(-200, 0, -300, 50);                  // both left: rejected
        send_segment(0, 200, 50, 300);                    // both above
        send_segment(200, 0, 300, -50);                   // both right
        send_segment(0, -200, -50, -300);                 // both below
        send_segment(0, 0, 0, 1000);                      // far end clipped at top
        send_segment(3, -1000, 7, 0);                     // near end clipped at bottom
        send_segment(1000, 1, 0, 0);                      // near end clipped at right
        send_segment(0, 0, -1000, -7);                    // left, negative quotient truncates
        send_segment(-1000, -900, 1000, 900);             // both ends clipped
        send_segment(-200, 100, -100, 200);               // touches the corner: clipped to one point
        send_segment(150, 150, -150, -150);               // ends on the edges, inclusive
        send_segment(151, -151, -151, 151);               // ends just outside two corners
        send_segment(5, 5, 5, 5);                         // zero length, inside
        send_segment(500, -500, 500, -500);               // zero length, outside
        send_segment(-1, -1, 32767, -32768);

        // Inverted window: runs out of crossings and saturates far crossings.
        set_window(100, -100, 100, -100);
        send_segment(0, 0, 0, 0);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(-32768, 32767, 32767, -32768);
        send_segment(0, -1000, 5, 1000);

        // Random batches, each under its own window. Phases: receiver mostly
        // stalled, then sender mostly idle, then both at full rate.
        for (batch = 0; batch < BATCHES; batch++)
        begin
            case (batch)
                0, 6: set_window(rand_in(-3000, 0), rand_in(0, 3000),
                                 rand_in(-3000, 0), rand_in(0, 3000));
                1: set_window(-32768, 32767, -32768, 32767);
                2:
                begin
                    // tiny window, a single point at times
                    xa = rand_in(-30000, 30000);
                    ya = rand_in(-30000, 30000);
                    set_window(xa, xa + rand_in(0, 3), ya, ya + rand_in(0, 3));
                end
                3:
                begin
                    xa = rand_in(-32768, 32767);
                    xb = rand_in(-32768, 32767);
                    ya = rand_in(-32768, 32767);
                    yb = rand_in(-32768, 32767);
                    set_window((xa < xb) ? xa : xb, (xa < xb) ? xb : xa,
                               (ya < yb) ? ya : yb, (ya < yb) ? yb : ya);
                end
                4: set_window(32000, 32767, -32768, -32000);
                5:
                begin
                    xa = rand_in(-500, 500);
                    ya = rand_in(-500, 500);
                    set_window(xa + rand_in(1, 300), xa, ya + rand_in(1, 300), ya);
                end
                default: set_window(-LSC_WIN_RESET, LSC_WIN_RESET,
                                    -LSC_WIN_RESET, LSC_WIN_RESET);
            endcase

            if (batch < 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct <= 75;
            end
            else if (batch < 6)
            begin
                send_idle_pct = 75;
                recv_idle_pct <= 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end

            for (n = 0; n < BATCH_ITEMS; n++)
            begin
                // sender keeps going through the hold-off and backs up the block
                if (n == 20 && (batch == 1 || batch == 4))
                    rx_hold_req <= rx_hold_req + 1;
                xa = pick_coord(wx_lo, wx_hi);
                ya = pick_coord(wy_lo, wy_hi);
                xb = pick_coord(wx_lo, wx_hi);
                yb = pick_coord(wy_lo, wy_hi);
                case ($urandom_range(7))
                    0: xb = xa;    // vertical
                    1: yb = ya;    // horizontal
                    default: ;
                endcase
                send_segment(xa, ya, xb, yb);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/lsc_pkg.sv
sv/lsc_cfg.sv
sv/lsc_muldiv.sv
sv/line_segment_clipper.sv
tb/line_segment_clipper_check.sv
tb/line_segment_clipper_test.sv
